[sv/bbal_pkg.sv]
// Shared types and constants for the bitmap block allocator.
// Holds the request and response beat formats, codes and the word-scan result.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bbal_pkg;

	// Map organization.
	localparam int WORD_BITS      = 32;
	localparam int WORD_SH        = 5;
	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int MAX_RUN        = 64;

	// Field widths.
	localparam int TYPE_W  = 2;
	localparam int START_W = 10;
	localparam int LEN_W   = 7;
	localparam int CFG_W   = 11;
	localparam int GRANT_W = 10;
	localparam int LIM_W   = WORD_SH + 1;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// Request kinds; the fourth code is rejected.
	typedef enum logic [TYPE_W-1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_RESERVE = 2'd2
	} req_kind_t;

	// Response status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  req_type;
		logic [START_W-1:0] start_block;
		logic [LEN_W-1:0]   run_length;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [GRANT_W-1:0] granted_block;
		logic [CFG_W-1:0]   used_blocks;
		logic [CFG_W-1:0]   free_blocks;
	} rsp_t;

	// Outcome of searching one map word for a free run.
	typedef struct packed {
		logic               found;
		logic [WORD_SH-1:0] pos;
		logic [LEN_W-1:0]   run_next;
	} scan_res_t;

endpackage

[sv/bitmap_block_allocator_unit.sv]
// Bitmap block allocator: one map bit per block and a used-block count. After reset the
// map is cleared one word per cycle (NUM_BLOCKS/32 words, 32 by default) before the first
// request is taken. A request occupies the block until its response is registered; a
// rejected request goes straight to the result state; an allocate searches map words (up
// to NUM_BLOCKS/32), then, if a run fits, passes the grant state, a map read and an update
// for each word the run touches (up to 3 for a 64-block run); a free or reserve does the
// map read and updates without a search. The single map read port delivers one 32-bit
// word per cycle and is shared by the word search and the read-modify-write logic.
// A finished response waits in its output register while the next request is accepted.
// Depends on bbal_pkg, bbal_map_ram and bbal_run_scan.
module bitmap_block_allocator_unit #(
	parameter int NUM_BLOCKS = bbal_pkg::NUM_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  bbal_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output bbal_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bbal_pkg::CFG_W-1:0]  cfg_data
);

	localparam int NB        = bbal_pkg::WORD_BITS;
	localparam int SH        = bbal_pkg::WORD_SH;
	localparam int MAP_WORDS = (NUM_BLOCKS + NB - 1) / NB;
	localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = ($clog2(NUM_BLOCKS + 1) > bbal_pkg::CFG_W) ?
	                           $clog2(NUM_BLOCKS + 1) : bbal_pkg::CFG_W;
	localparam int IDX_W     = CNT_W + 1;
	localparam int PC_W      = SH + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_GRANT,
		S_MARK_RD,
		S_MARK,
		S_RESULT
	} state_t;

	state_t                          state_q;
	logic [WORD_W-1:0]               word_q;
	logic [WORD_W-1:0]               last_word_q;
	logic [CNT_W-1:0]                rem_q;
	logic [bbal_pkg::LEN_W-1:0]      run_q;
	logic [bbal_pkg::LEN_W-1:0]      len_q;
	logic [IDX_W-1:0]                start_q;
	logic [IDX_W-1:0]                end_q;
	logic                            set_q;
	bbal_pkg::status_t               status_q;
	logic [bbal_pkg::GRANT_W-1:0]    granted_q;
	logic [CNT_W-1:0]                used_q;
	logic [bbal_pkg::CFG_W-1:0]      cfg_q;
	bbal_pkg::rsp_t                  rsp_q;
	logic                            rsp_valid_q;

	logic [CNT_W-1:0]                blocks_eff;
	logic [IDX_W-1:0]                req_start;
	logic [IDX_W-1:0]                req_end;
	logic [IDX_W-1:0]                req_last;
	logic                            req_bad;
	logic                            range_bad;
	logic [bbal_pkg::LIM_W-1:0]      limit;
	bbal_pkg::scan_res_t             scan_res;
	logic [IDX_W-1:0]                scan_end;
	logic [IDX_W-1:0]                grant_start;
	logic [NB-1:0]                   rd_data;
	logic [WORD_W-1:0]               rd_addr;
	logic                            wr_en;
	logic [WORD_W-1:0]               wr_addr;
	logic [NB-1:0]                   wr_data;
	logic [NB-1:0]                   mark_mask;
	logic [NB-1:0]                   chg;
	logic [NB-1:0]                   new_word;
	logic [1:0]                      pc1 [0:15];
	logic [2:0]                      pc2 [0:7];
	logic [3:0]                      pc3 [0:3];
	logic [4:0]                      pc4 [0:1];
	logic [PC_W-1:0]                 chg_cnt;
	logic [CNT_W-1:0]                used_next;
	logic [CNT_W-1:0]                free_cnt;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// Effective block count is the register clipped to the map size.
	assign blocks_eff = (CNT_W'(cfg_q) > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) :
	                    CNT_W'(cfg_q);

	// Request checks for the incoming beat.
	always_comb begin
		req_start = IDX_W'(req.start_block);
		req_end   = req_start + IDX_W'(req.run_length);
		req_last  = req_end - IDX_W'(1);
		req_bad   = (req.req_type != bbal_pkg::REQ_ALLOC &&
		             req.req_type != bbal_pkg::REQ_FREE &&
		             req.req_type != bbal_pkg::REQ_RESERVE) ||
		            (req.run_length == '0) ||
		            (int'(req.run_length) > bbal_pkg::MAX_RUN);
		range_bad = (req_end > IDX_W'(blocks_eff));
	end

	// Word search for allocation.
	assign limit = (rem_q >= CNT_W'(NB)) ? bbal_pkg::LIM_W'(NB) :
	               rem_q[bbal_pkg::LIM_W-1:0];

	bbal_run_scan u_scan (
		.map_word (rd_data),
		.limit    (limit),
		.run_in   (run_q),
		.run_len  (len_q),
		.res      (scan_res)
	);

	assign scan_end    = IDX_W'({word_q, scan_res.pos}) + IDX_W'(1);
	assign grant_start = end_q - IDX_W'(len_q);

	// Run mask and changed bits for the word under read-modify-write.
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			mark_mask[j] = (IDX_W'({word_q, SH'(j)}) >= start_q) &&
			               (IDX_W'({word_q, SH'(j)}) < end_q);
		end
		chg      = mark_mask & (set_q ? ~rd_data : rd_data);
		new_word = set_q ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
	end

	// Population count of the changed bits as an adder tree.
	always_comb begin
		for (int j = 0; j < 16; j++) begin
			pc1[j] = 2'(chg[2*j]) + 2'(chg[2*j+1]);
		end
		for (int j = 0; j < 8; j++) begin
			pc2[j] = 3'(pc1[2*j]) + 3'(pc1[2*j+1]);
		end
		for (int j = 0; j < 4; j++) begin
			pc3[j] = 4'(pc2[2*j]) + 4'(pc2[2*j+1]);
		end
		for (int j = 0; j < 2; j++) begin
			pc4[j] = 5'(pc3[2*j]) + 5'(pc3[2*j+1]);
		end
		chg_cnt = PC_W'(pc4[0]) + PC_W'(pc4[1]);
	end

	// Used count after this word; a decrement floors at zero.
	always_comb begin
		if (set_q) begin
			used_next = used_q + CNT_W'(chg_cnt);
		end else if (used_q > CNT_W'(chg_cnt)) begin
			used_next = used_q - CNT_W'(chg_cnt);
		end else begin
			used_next = '0;
		end
	end

	assign free_cnt = (blocks_eff > used_q) ? (blocks_eff - used_q) : '0;

	// Map port control: clearing pass, search reads and run updates.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = new_word;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
				rd_addr = word_q;
			end
			S_IDLE:    rd_addr = '0;
			S_SCAN:    rd_addr = word_q + WORD_W'(1);
			S_MARK_RD: rd_addr = word_q;
			S_MARK: begin
				wr_en   = 1'b1;
				rd_addr = word_q + WORD_W'(1);
			end
			default:   rd_addr = word_q;
		endcase
	end

	bbal_map_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (WORD_W)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer, counters and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			word_q      <= '0;
			last_word_q <= '0;
			rem_q       <= '0;
			run_q       <= '0;
			len_q       <= '0;
			start_q     <= '0;
			end_q       <= '0;
			set_q       <= 1'b0;
			status_q    <= bbal_pkg::ST_OK;
			granted_q   <= '0;
			used_q      <= '0;
			cfg_q       <= bbal_pkg::CFG_RESET;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			// A new response loads when the output register is free or being taken.
			if (state_q == S_RESULT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (word_q == WORD_W'(MAP_WORDS - 1)) begin
						word_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						word_q <= word_q + WORD_W'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						granted_q <= '0;
						len_q     <= req.run_length;
						run_q     <= '0;
						rem_q     <= blocks_eff;
						if (req_bad) begin
							status_q <= bbal_pkg::ST_BAD;
							word_q   <= '0;
							state_q  <= S_RESULT;
						end else if (req.req_type == bbal_pkg::REQ_ALLOC) begin
							status_q <= bbal_pkg::ST_OK;
							word_q   <= '0;
							state_q  <= S_SCAN;
						end else if (range_bad) begin
							status_q <= bbal_pkg::ST_BAD;
							word_q   <= '0;
							state_q  <= S_RESULT;
						end else begin
							status_q    <= bbal_pkg::ST_OK;
							start_q     <= req_start;
							end_q       <= req_end;
							set_q       <= (req.req_type == bbal_pkg::REQ_RESERVE);
							word_q      <= req_start[SH +: WORD_W];
							last_word_q <= req_last[SH +: WORD_W];
							state_q     <= S_MARK_RD;
						end
					end
				end
				S_SCAN: begin
					if (scan_res.found) begin
						end_q       <= scan_end;
						last_word_q <= word_q;
						state_q     <= S_GRANT;
					end else if (rem_q <= CNT_W'(NB)) begin
						status_q <= bbal_pkg::ST_NO_ROOM;
						state_q  <= S_RESULT;
					end else begin
						word_q <= word_q + WORD_W'(1);
						rem_q  <= rem_q - CNT_W'(NB);
						run_q  <= scan_res.run_next;
					end
				end
				S_GRANT: begin
					start_q   <= grant_start;
					word_q    <= grant_start[SH +: WORD_W];
					granted_q <= grant_start[bbal_pkg::GRANT_W-1:0];
					set_q     <= 1'b1;
					state_q   <= S_MARK_RD;
				end
				S_MARK_RD: begin
					state_q <= S_MARK;
				end
				S_MARK: begin
					used_q <= used_next;
					if (word_q == last_word_q) begin
						state_q <= S_RESULT;
					end else begin
						word_q <= word_q + WORD_W'(1);
					end
				end
				S_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status        <= status_q;
						rsp_q.granted_block <= (status_q == bbal_pkg::ST_OK) ? granted_q : '0;
						rsp_q.used_blocks   <= used_q[bbal_pkg::CFG_W-1:0];
						rsp_q.free_blocks   <= free_cnt[bbal_pkg::CFG_W-1:0];
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/bbal_map_ram.sv]
// Usage map storage: one 32-bit word per row, one write port and one read port.
// Read data is registered. Uses bbal_pkg for the word width and default depth.
module bbal_map_ram #(
	parameter int DEPTH = bbal_pkg::NUM_BLOCKS_DEF / bbal_pkg::WORD_BITS,
	parameter int AW    = 5
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [bbal_pkg::WORD_BITS-1:0] wr_data,
	input  logic [AW-1:0]                  rd_addr,
	output logic [bbal_pkg::WORD_BITS-1:0] rd_data
);

	logic [bbal_pkg::WORD_BITS-1:0] mem [0:DEPTH-1];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[sv/bbal_run_scan.sv]
// Searches one map word for the lowest position where a free run reaches the
// requested length, continuing a run carried in from lower words. Uses bbal_pkg.
module bbal_run_scan (
	input  logic [bbal_pkg::WORD_BITS-1:0] map_word,
	input  logic [bbal_pkg::LIM_W-1:0]     limit,
	input  logic [bbal_pkg::LEN_W-1:0]     run_in,
	input  logic [bbal_pkg::LEN_W-1:0]     run_len,
	output bbal_pkg::scan_res_t            res
);

	localparam int NB = bbal_pkg::WORD_BITS;
	localparam int LV = bbal_pkg::WORD_SH;
	localparam int RW = bbal_pkg::LEN_W + 1;

	logic [NB-1:0]                used;
	logic [bbal_pkg::LIM_W-1:0]   lvl [0:LV][0:NB-1];
	logic [RW-1:0]                rl;
	logic [NB-1:0]                hit;
	logic [bbal_pkg::LIM_W-1:0]   top;

	// Bits at or above the managed limit count as used.
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			used[j] = map_word[j] | (bbal_pkg::LIM_W'(j) >= limit);
		end
	end

	// Prefix search: for each position, one plus the nearest used bit at or below it.
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			lvl[0][j] = used[j] ? bbal_pkg::LIM_W'(j + 1) : '0;
		end
		for (int k = 0; k < LV; k++) begin
			for (int j = 0; j < NB; j++) begin
				if (j >= (1 << k) && lvl[k][j] == '0) begin
					lvl[k+1][j] = lvl[k][j - (1 << k)];
				end else begin
					lvl[k+1][j] = lvl[k][j];
				end
			end
		end
	end

	// Run length ending at each position and the lowest position that fits.
	always_comb begin
		rl  = '0;
		hit = '0;
		for (int j = 0; j < NB; j++) begin
			if (lvl[LV][j] == '0) begin
				rl = RW'(run_in) + RW'(j + 1);
			end else begin
				rl = RW'(j + 1) - RW'(lvl[LV][j]);
			end
			hit[j] = (rl >= RW'(run_len));
		end
	end

	// Priority pick and the free run that leaves the top of the word.
	always_comb begin
		res.found = |hit;
		res.pos   = '0;
		for (int j = NB - 1; j >= 0; j--) begin
			if (hit[j]) begin
				res.pos = bbal_pkg::WORD_SH'(j);
			end
		end
		top = lvl[LV][NB-1];
		if (top == '0) begin
			res.run_next = bbal_pkg::LEN_W'(RW'(run_in) + RW'(NB));
		end else begin
			res.run_next = bbal_pkg::LEN_W'(bbal_pkg::LIM_W'(NB) - top);
		end
	end

endmodule
